[rtl/jcfp_pkg.sv]
// Shared types, constants and decode helpers for the joystick command frame parser.
package jcfp_pkg;

  localparam logic [7:0] START_BYTE_RESET = 8'h02;
  localparam logic [7:0] END_BYTE_RESET   = 8'h03;

  localparam int unsigned PAYLOAD_DEPTH = 6;
  localparam int unsigned FILL_W        = 4;
  localparam logic [FILL_W-1:0] FILL_MAX = 4'd8;

  localparam logic [2:0] LEN_BUTTON_M1 = 3'd2;
  localparam logic [2:0] LEN_JOY_M1    = 3'd7;

  localparam logic [7:0] LETTER_FIRST = 8'h41;
  localparam logic [7:0] LETTER_LAST  = 8'h4C;

  localparam int unsigned COORD_W = 16;
  localparam logic signed [COORD_W-1:0] ASCII_ZERO   = 16'sd48;
  localparam logic signed [COORD_W-1:0] COORD_OFFSET = 16'sd200;
  localparam logic signed [COORD_W-1:0] COORD_MAX    = 16'sd100;
  localparam logic signed [COORD_W-1:0] COORD_MIN    = -16'sd100;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_BUTTON = 2'd1,
    KIND_JOY    = 2'd2,
    KIND_OTHER  = 2'd3
  } frame_kind_e;

  typedef enum logic {
    CFG_START = 1'b0,
    CFG_END   = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic       closed;
    logic [2:0] len_m1;
  } close_t;

  typedef struct packed {
    logic [2:0]        frame_len;
    frame_kind_e       frame_kind;
    logic signed [7:0] joy_x;
    logic signed [7:0] joy_y;
    logic [5:0]        button_bits;
    logic              reply_due;
    logic              coord_error;
  } result_t;

  // Three ASCII digits, each taken as code minus '0', less the 200 offset.
  function automatic logic signed [COORD_W-1:0] three_digits(
    input logic [7:0] hi,
    input logic [7:0] mid,
    input logic [7:0] lo
  );
    logic signed [COORD_W-1:0] a;
    logic signed [COORD_W-1:0] b;
    logic signed [COORD_W-1:0] c;
    a = signed'({8'h00, hi}) - ASCII_ZERO;
    b = signed'({8'h00, mid}) - ASCII_ZERO;
    c = signed'({8'h00, lo}) - ASCII_ZERO;
    return a * 16'sd100 + b * 16'sd10 + c - COORD_OFFSET;
  endfunction

endpackage

[rtl/jcfp_framer.sv]
// Frame tracker: fill count, payload store and frame close detection.
module jcfp_framer (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     step_i,
  input  logic [7:0]                               byte_i,
  input  logic [7:0]                               start_byte_i,
  input  logic [7:0]                               end_byte_i,
  output jcfp_pkg::close_t                         close_o,
  output logic [jcfp_pkg::PAYLOAD_DEPTH-1:0][7:0]  payload_o
);
  import jcfp_pkg::*;

  logic [FILL_W-1:0]                fill_q, fill_d;
  logic [PAYLOAD_DEPTH-1:0][7:0]    payload_q;
  logic                             wr_en;
  logic [2:0]                       wr_addr;

  assign wr_addr = fill_q[2:0] - 3'd1;

  always_comb begin
    fill_d  = fill_q;
    close_o = '0;
    wr_en   = 1'b0;
    if (fill_q == '0) begin
      if (byte_i == start_byte_i) fill_d = FILL_W'(1);
    end else if (fill_q < FILL_MAX) begin
      wr_en  = (fill_q <= FILL_W'(PAYLOAD_DEPTH));
      fill_d = fill_q + FILL_W'(1);
      if (byte_i == end_byte_i) begin
        close_o.closed = 1'b1;
        close_o.len_m1 = fill_q[2:0];
        fill_d         = '0;
      end
    end else begin
      // overflow: drop the byte and fall back to hunting for a start
      fill_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (step_i) begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && wr_en) begin
      payload_q[wr_addr] <= byte_i;
    end
  end

  assign payload_o = payload_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) fill_q <= FILL_MAX)
    else $error("fill count past frame limit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && close_o.closed |=> fill_q == '0)
    else $error("fill count not cleared after frame close");

endmodule

[rtl/jcfp_decoder.sv]
// Command decoder: button and joystick state and the per-byte result.
module jcfp_decoder (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     step_i,
  input  jcfp_pkg::close_t                         close_i,
  input  logic [jcfp_pkg::PAYLOAD_DEPTH-1:0][7:0]  payload_i,
  output jcfp_pkg::result_t                        res_o
);
  import jcfp_pkg::*;

  logic [5:0]                button_q, button_d;
  logic signed [7:0]         x_q, x_d;
  logic signed [7:0]         y_q, y_d;
  logic signed [COORD_W-1:0] x_val, y_val;
  logic [7:0]                letter;
  logic [7:0]                idx;
  logic [2:0]                bit_sel;
  frame_kind_e               kind;
  logic                      reply;
  logic                      err;

  assign x_val   = three_digits(payload_i[0], payload_i[1], payload_i[2]);
  assign y_val   = three_digits(payload_i[3], payload_i[4], payload_i[5]);
  assign letter  = payload_i[0];
  assign idx     = letter - LETTER_FIRST;
  assign bit_sel = idx[3:1];

  always_comb begin
    kind     = KIND_NONE;
    reply    = 1'b0;
    err      = 1'b0;
    button_d = button_q;
    x_d      = x_q;
    y_d      = y_q;
    if (close_i.closed) begin
      case (close_i.len_m1)
        LEN_BUTTON_M1: begin
          kind  = KIND_BUTTON;
          reply = 1'b1;
          // letters at an even offset from 'A' set a button, odd offsets clear it
          if (letter inside {[LETTER_FIRST:LETTER_LAST]}) begin
            button_d[bit_sel] = ~idx[0];
          end
        end
        LEN_JOY_M1: begin
          kind  = KIND_JOY;
          reply = 1'b1;
          if (x_val < COORD_MIN || x_val > COORD_MAX ||
              y_val < COORD_MIN || y_val > COORD_MAX) begin
            err = 1'b1;
          end else begin
            x_d = x_val[7:0];
            y_d = y_val[7:0];
          end
        end
        default: begin
          kind = KIND_OTHER;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      button_q <= '0;
      x_q      <= '0;
      y_q      <= '0;
    end else if (step_i) begin
      button_q <= button_d;
      x_q      <= x_d;
      y_q      <= y_d;
    end
  end

  always_comb begin
    res_o.frame_len   = close_i.closed ? close_i.len_m1 : 3'd0;
    res_o.frame_kind  = kind;
    res_o.joy_x       = x_d;
    res_o.joy_y       = y_d;
    res_o.button_bits = button_d;
    res_o.reply_due   = reply;
    res_o.coord_error = err;
  end

endmodule

[rtl/joystick_command_frame_parser.sv]
// Top level of the joystick command frame parser: handshakes, config and result register.
//
// One result per received byte. A byte is accepted every cycle while the result side
// keeps up; its result is decoded on the way from the input register into the result
// register, which it enters when the result register frees up. Start and end byte
// codes reset to STX and ETX and are written through the config port, which is always
// ready and must only be used while the parser is idle.
module joystick_command_frame_parser (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic                     cfg_index_i,
  input  logic [7:0]               cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [7:0]               rx_byte_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [2:0]               frame_len_o,
  output logic [1:0]               frame_kind_o,
  output logic signed [7:0]        joy_x_o,
  output logic signed [7:0]        joy_y_o,
  output logic [5:0]               button_bits_o,
  output logic                     reply_due_o,
  output logic                     coord_error_o
);
  import jcfp_pkg::*;

  logic [7:0]                    start_q;
  logic [7:0]                    end_q;
  logic                          s1_valid_q;
  logic [7:0]                    s1_byte_q;
  logic                          out_valid_q;
  result_t                       out_q;
  result_t                       res;
  close_t                        close_info;
  logic [PAYLOAD_DEPTH-1:0][7:0] payload;
  logic                          adv;
  logic                          step;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= START_BYTE_RESET;
      end_q   <= END_BYTE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_START: start_q <= cfg_data_i;
        CFG_END:   end_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // result register frees up when empty or when its request is taken
  assign adv        = !out_valid_q || !out_stall_i;
  assign step       = s1_valid_q && adv;
  assign in_stall_o = s1_valid_q && !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      s1_valid_q <= 1'b1;
    end else if (step) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_byte_q <= rx_byte_i;
    end
  end

  jcfp_framer u_framer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .byte_i       (s1_byte_q),
    .start_byte_i (start_q),
    .end_byte_i   (end_q),
    .close_o      (close_info),
    .payload_o    (payload)
  );

  jcfp_decoder u_decoder (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .close_i   (close_info),
    .payload_i (payload),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign frame_len_o   = out_q.frame_len;
  assign frame_kind_o  = out_q.frame_kind;
  assign joy_x_o       = out_q.joy_x;
  assign joy_y_o       = out_q.joy_y;
  assign button_bits_o = out_q.button_bits;
  assign reply_due_o   = out_q.reply_due;
  assign coord_error_o = out_q.coord_error;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_kind_o == KIND_NONE |->
      !reply_due_o && !coord_error_o && frame_len_o == 3'd0)
    else $error("frame flags set without a closed frame");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && coord_error_o |-> frame_kind_o == KIND_JOY && reply_due_o)
    else $error("coordinate error outside a joystick frame");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !adv |=> s1_valid_q && $stable(s1_byte_q))
    else $error("held input byte lost while result side stalled");

endmodule
